>>> hw/rtl/actr_pkg.sv
// Package for the AES-128 counter-mode byte decryptor: state types, S-box,
// round-constant table and GF(2^8) round helpers. No dependencies.
`timescale 1ns / 1ps
package actr_pkg;

   localparam int ROUNDS = 10;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;
   typedef logic [1:0]   csr_index_type;

   localparam csr_index_type CSR_KEY_LOW  = 2'd0;
   localparam csr_index_type CSR_KEY_HIGH = 2'd1;
   localparam csr_index_type CSR_CTR_LOW  = 2'd2;
   localparam csr_index_type CSR_CTR_HIGH = 2'd3;

   // Side data that travels with each beat through the rounds.
   typedef struct packed {
      logic     valid;
      logic [3:0] lane;
      byte_type cipher;
   } beat_type;

   function automatic byte_type sbox(input byte_type b);
      byte_type r;
      case (b)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r=8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type rcon(input logic [3:0] round);
      byte_type r;
      case (round)
         4'd1: r=8'h01; 4'd2: r=8'h02; 4'd3: r=8'h04; 4'd4: r=8'h08;
         4'd5: r=8'h10; 4'd6: r=8'h20; 4'd7: r=8'h40; 4'd8: r=8'h80;
         4'd9: r=8'h1b; 4'd10: r=8'h36;
         default: r=8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type xtime(input byte_type b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a block sits in bits 8*i+7:8*i.
   function automatic byte_type get_byte(input block_type b, input int i);
      return b[8*i +: 8];
   endfunction

   // Next round key from the previous one.
   function automatic block_type next_key(input block_type k, input logic [3:0] round);
      block_type n;
      byte_type t0, t1, t2, t3;
      t0 = sbox(k[13*8 +: 8]) ^ rcon(round);
      t1 = sbox(k[14*8 +: 8]);
      t2 = sbox(k[15*8 +: 8]);
      t3 = sbox(k[12*8 +: 8]);
      n[31:0]   = k[31:0] ^ {t3, t2, t1, t0};
      n[63:32]  = k[63:32] ^ n[31:0];
      n[95:64]  = k[95:64] ^ n[63:32];
      n[127:96] = k[127:96] ^ n[95:64];
      return n;
   endfunction

   // SubBytes, ShiftRows and, unless last, MixColumns.
   function automatic block_type round_fn(input block_type s, input logic last);
      block_type t, m;
      byte_type a0, a1, a2, a3, x;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[(c*4+r)*8 +: 8] = sbox(s[((((c + r) & 3) * 4) + r)*8 +: 8]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[(c*4)*8 +: 8];
         a1 = t[(c*4+1)*8 +: 8];
         a2 = t[(c*4+2)*8 +: 8];
         a3 = t[(c*4+3)*8 +: 8];
         x  = a0 ^ a1 ^ a2 ^ a3;
         m[(c*4)*8 +: 8]   = a0 ^ x ^ xtime(a0 ^ a1);
         m[(c*4+1)*8 +: 8] = a1 ^ x ^ xtime(a1 ^ a2);
         m[(c*4+2)*8 +: 8] = a2 ^ x ^ xtime(a2 ^ a3);
         m[(c*4+3)*8 +: 8] = a3 ^ x ^ xtime(a3 ^ a0);
      end
      return last ? t : m;
   endfunction

endpackage

>>> hw/rtl/actr_keysched.sv
// Round-key schedule: recomputes all eleven round keys from the key registers.
// Keys one to ten are registered per round; key zero is the key input itself. Depends on actr_pkg.
`timescale 1ns / 1ps
module actr_keysched (
   input  logic                clock,
   input  actr_pkg::block_type key,
   output actr_pkg::block_type round_keys [0:actr_pkg::ROUNDS]
);

   actr_pkg::block_type rk_ff [1:actr_pkg::ROUNDS];

   assign round_keys[0] = key;

   always_ff @(posedge clock) begin
      rk_ff[1] <= actr_pkg::next_key(key, 4'd1);
      for (int r = 2; r <= actr_pkg::ROUNDS; r++) begin
         rk_ff[r] <= actr_pkg::next_key(rk_ff[r-1], 4'(r));
      end
   end

   for (genvar g = 1; g <= actr_pkg::ROUNDS; g++) begin : g_out
      assign round_keys[g] = rk_ff[g];
   end

endmodule

>>> hw/rtl/actr_round.sv
// One AES round stage with pipeline register and side data.
// Depends on actr_pkg.
`timescale 1ns / 1ps
module actr_round #(
   parameter bit LAST = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  actr_pkg::block_type state_in,
   input  actr_pkg::beat_type  beat_in,
   input  actr_pkg::block_type round_key,
   output actr_pkg::block_type state_out,
   output actr_pkg::beat_type  beat_out
);

   actr_pkg::block_type state_ff;
   actr_pkg::beat_type  beat_ff;

   always_ff @(posedge clock) begin
      state_ff <= actr_pkg::round_fn(state_in, LAST) ^ round_key;
      beat_ff.lane   <= beat_in.lane;
      beat_ff.cipher <= beat_in.cipher;
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
   end

   assign state_out = state_ff;
   assign beat_out  = beat_ff;

endmodule

>>> hw/rtl/aes_ctr_seekable_byte_decrypt.sv
// Top level of the AES-128 counter-mode byte decryptor with seekable position.
// Uses actr_pkg, actr_keysched and actr_round.
//
//  channel | ports                                   | direction
//  req     | start, busy, req_byte_position, req_cipher_byte | in (busy out)
//  rsp     | rsp_valid, rsp_plain_byte               | out
//  csr     | csr_valid, csr_ready, csr_index, csr_data | in (csr_ready out)
//
// One byte is accepted every cycle; busy is always low. A result reaches the
// response ports through the counter stage, which registers at the edge that
// accepts its beat, then ten round stages and one output stage.
// Reset clears the valid bits and the four registers to zero. The receiver
// cannot stall, so nothing in the pipeline ever holds.
`timescale 1ns / 1ps
module aes_ctr_seekable_byte_decrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_byte_position,
   input  logic [7:0]  req_cipher_byte,
   output logic        rsp_valid,
   output logic [7:0]  rsp_plain_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] key_low_ff, key_high_ff, ctr_low_ff, ctr_high_ff;
   actr_pkg::block_type rkeys [0:actr_pkg::ROUNDS];
   actr_pkg::block_type st [0:actr_pkg::ROUNDS];
   actr_pkg::beat_type  bt [0:actr_pkg::ROUNDS];
   actr_pkg::beat_type  beat_in;
   logic [64:0] lo_sum;
   actr_pkg::block_type ctr_in;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         ctr_low_ff  <= '0;
         ctr_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            actr_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_data;
            actr_pkg::CSR_KEY_HIGH: key_high_ff <= csr_data;
            actr_pkg::CSR_CTR_LOW:  ctr_low_ff  <= csr_data;
            actr_pkg::CSR_CTR_HIGH: ctr_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   actr_keysched u_keys (
      .clock      (clock),
      .key        ({key_high_ff, key_low_ff}),
      .round_keys (rkeys)
   );

   // Counter stage: form the counter block and whiten with round key zero.
   assign lo_sum = {1'b0, ctr_low_ff} + {37'd0, req_byte_position[31:4]};
   assign ctr_in = {ctr_high_ff + {63'd0, lo_sum[64]}, lo_sum[63:0]};
   assign beat_in.valid  = start && !busy;
   assign beat_in.lane   = req_byte_position[3:0];
   assign beat_in.cipher = req_cipher_byte;

   actr_pkg::block_type st0_ff;
   actr_pkg::beat_type  bt0_ff;

   always_ff @(posedge clock) begin
      st0_ff <= ctr_in ^ rkeys[0];
      bt0_ff.lane   <= beat_in.lane;
      bt0_ff.cipher <= beat_in.cipher;
      if (reset) begin
         bt0_ff.valid <= 1'b0;
      end else begin
         bt0_ff.valid <= beat_in.valid;
      end
   end

   assign st[0] = st0_ff;
   assign bt[0] = bt0_ff;

   // Round key r comes from the r-th schedule register, so it stays aligned; the user
   // ensures configuration only changes while the pipe is empty; the block does not.
   for (genvar g = 1; g <= actr_pkg::ROUNDS; g++) begin : g_round
      actr_round #(.LAST(g == actr_pkg::ROUNDS)) u_round (
         .clock     (clock),
         .reset     (reset),
         .state_in  (st[g-1]),
         .beat_in   (bt[g-1]),
         .round_key (rkeys[g]),
         .state_out (st[g]),
         .beat_out  (bt[g])
      );
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= bt[actr_pkg::ROUNDS].cipher
                     ^ st[actr_pkg::ROUNDS][{bt[actr_pkg::ROUNDS].lane, 3'b000} +: 8];
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= bt[actr_pkg::ROUNDS].valid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_byte = rsp_byte_ff;

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      bt[actr_pkg::ROUNDS].valid |=> rsp_valid)
      else $error("final round beat did not reach the output");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !bt[actr_pkg::ROUNDS].valid |=> !rsp_valid)
      else $error("response without a beat");
   a_first_stage: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> bt[0].valid)
      else $error("accepted beat lost at counter stage");

endmodule

>>> sim/aes_ctr_seekable_byte_decrypt_check.sv
// Checker for the AES-128 counter-mode byte decryptor: watches the request, response
// and register channels, predicts each plain byte and compares. Depends on actr_pkg.
`timescale 1ns / 1ps
module aes_ctr_seekable_byte_decrypt_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_byte_position,
   input  logic [7:0]  req_cipher_byte,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_plain_byte,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          failures,
   output int          pending,
   output int          checked
);

   localparam logic [7:0] SUB_TABLE [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
      8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
      8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
      8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
      8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
      8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
      8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
      8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
      8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
      8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
      8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
      8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
      8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
      8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
      8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
      8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
      8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   logic [63:0] key_lo, key_hi, ctr_lo, ctr_hi;
   logic [7:0]  plain_queue [$];

   function automatic logic [7:0] dbl(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] keystream_byte(input logic [31:0] pos);
      logic [7:0] st [16];
      logic [7:0] sh [16];
      logic [7:0] rk [16];
      logic [7:0] t0, t1, t2, t3, a0, a1, a2, a3, al, rc;
      logic [63:0] lo, hi;
      logic [127:0] kb, cb;
      lo = ctr_lo + 64'(pos >> 4);
      hi = ctr_hi + ((lo < 64'(pos >> 4)) ? 64'd1 : 64'd0);
      kb = {key_hi, key_lo};
      cb = {hi, lo};
      for (int i = 0; i < 16; i++) begin
         rk[i] = kb[8*i +: 8];
         st[i] = cb[8*i +: 8] ^ rk[i];
      end
      rc = 8'h01;
      for (int rnd = 1; rnd <= 10; rnd++) begin
         t0 = SUB_TABLE[rk[13]] ^ rc;
         t1 = SUB_TABLE[rk[14]];
         t2 = SUB_TABLE[rk[15]];
         t3 = SUB_TABLE[rk[12]];
         rk[0] ^= t0; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
         for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
         rc = dbl(rc);
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               sh[c*4+r] = SUB_TABLE[st[((c+r)&3)*4+r]];
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = sh[c*4]; a1 = sh[c*4+1]; a2 = sh[c*4+2]; a3 = sh[c*4+3];
               al = a0 ^ a1 ^ a2 ^ a3;
               st[c*4]   = a0 ^ al ^ dbl(a0 ^ a1);
               st[c*4+1] = a1 ^ al ^ dbl(a1 ^ a2);
               st[c*4+2] = a2 ^ al ^ dbl(a2 ^ a3);
               st[c*4+3] = a3 ^ al ^ dbl(a3 ^ a0);
            end
         end else begin
            st = sh;
         end
         for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      end
      return st[pos[3:0]];
   endfunction

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         key_lo <= '0; key_hi <= '0; ctr_lo <= '0; ctr_hi <= '0;
         plain_queue.delete();
         failures <= 0;
         checked <= 0;
         pending <= 0;
      end else begin
         if (rsp_valid) begin
            if (plain_queue.size() == 0) begin
               $display("%0t: unexpected plain byte, expected none, actual %h",
                        $time, rsp_plain_byte);
               failures <= failures + 1;
            end else begin
               want = plain_queue.pop_front();
               checked <= checked + 1;
               if (want !== rsp_plain_byte) begin
                  $display("%0t: plain_byte mismatch, expected %h, actual %h",
                           $time, want, rsp_plain_byte);
                  failures <= failures + 1;
               end
            end
         end
         if (start && !busy)
            plain_queue.push_back(req_cipher_byte ^ keystream_byte(req_byte_position));
         pending <= plain_queue.size();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               actr_pkg::CSR_KEY_LOW:  key_lo <= csr_data;
               actr_pkg::CSR_KEY_HIGH: key_hi <= csr_data;
               actr_pkg::CSR_CTR_LOW:  ctr_lo <= csr_data;
               actr_pkg::CSR_CTR_HIGH: ctr_hi <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

>>> sim/aes_ctr_seekable_byte_decrypt_test.sv
// Testbench top for the AES-128 counter-mode byte decryptor: drives byte beats
// and register writes, and gives the verdict. Depends on actr_pkg and the checker.
`timescale 1ns / 1ps
module aes_ctr_seekable_byte_decrypt_test;

   logic        clock, reset, start, busy, rsp_valid, csr_valid, csr_ready;
   logic [31:0] req_byte_position;
   logic [7:0]  req_cipher_byte, rsp_plain_byte;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;
   int          failures, pending, checked;
   int          beats_sent;

   aes_ctr_seekable_byte_decrypt dut (.*);
   aes_ctr_seekable_byte_decrypt_check checker_inst (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   task automatic write_reg(input actr_pkg::csr_index_type idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_all(input logic [63:0] kl, kh, cl, ch);
      write_reg(actr_pkg::CSR_KEY_LOW, kl);
      write_reg(actr_pkg::CSR_KEY_HIGH, kh);
      write_reg(actr_pkg::CSR_CTR_LOW, cl);
      write_reg(actr_pkg::CSR_CTR_HIGH, ch);
   endtask

   task automatic send_byte(input logic [31:0] pos, input logic [7:0] cb, input bit gaps);
      if (gaps && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(7, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_byte_position <= pos;
      req_cipher_byte <= cb;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      logic [31:0] base;
      reset = 1'b1; start = 1'b0; csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      req_byte_position = '0; req_cipher_byte = '0; beats_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Reset registers, then extremes of position and data.
      send_byte(32'd0, 8'h00, 0);
      send_byte(32'hffffffff, 8'hff, 0);
      send_byte(32'd15, 8'hff, 0);
      send_byte(32'd16, 8'h00, 0);
      drain();
      set_all('1, '1, '1, '1);
      send_byte(32'd0, 8'ha5, 0);
      send_byte(32'd16, 8'h5a, 0);
      send_byte(32'hffffffff, 8'h00, 0);
      drain();
      // Carry out of the low half, and high half wrapping.
      set_all(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'hfffffffffffffffe, '1);
      for (int i = 0; i < 6; i++) send_byte(32'(i * 16 + i), 8'(i), 0);
      drain();
      write_reg(actr_pkg::CSR_CTR_HIGH, 64'h0123456789abcdef);
      for (int i = 0; i < 6; i++) send_byte(32'(i * 8), 8'(8'hf0 + i), 0);
      drain();
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 2)
            set_all(rand64(), rand64(),
                    64'hffffffffffffff00 | 64'($urandom_range(255)), rand64());
         else
            set_all(rand64(), rand64(), rand64(), rand64());
         base = $urandom();
         for (int i = 0; i < 100; i++) begin
            if ($urandom_range(3) == 0)
               send_byte($urandom(), 8'($urandom()), phase < 4);
            else
               send_byte(base + 32'(i), 8'($urandom()), phase < 4);
         end
         drain();
      end
      $display("Covered %0d byte beats, %0d plain bytes checked, over several key and",
               beats_sent, checked);
      $display("counter settings including all-zero, all-one and carry-wrapping counters.");
      if (failures == 0) begin
         $display("aes_ctr_seekable_byte_decrypt regression: pass");
      end else begin
         $display("aes_ctr_seekable_byte_decrypt regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("aes_ctr_seekable_byte_decrypt regression: fail");
      $finish;
   end
endmodule
